/* hdl/fp64_rem_pkg.sv */
// ----------------------------------------------------------------------------
// fp64_rem_pkg
// Types and constants for the binary64 truncated remainder block.
// ----------------------------------------------------------------------------
package fp64_rem_pkg;

  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  localparam logic [63:0] CanonNan   = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic [63:0] a_bits;
    logic [63:0] b_bits;
  } in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        invalid_flag;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NORM,
    ST_DONE
  } state_e;

endpackage

/* hdl/fp64_truncated_remainder.sv */
// ----------------------------------------------------------------------------
// fp64_truncated_remainder
// Exact fmod of two binary64 values by restoring shift and subtract.
// ----------------------------------------------------------------------------
// From accept to result: special cases go straight to the result; otherwise
// (eae - ebe + 53) reduction steps and up to 52 normalize shifts follow,
// one bit per cycle through one subtractor.
// Throughput: one transaction at a time; the next can be accepted in the cycle
// after the result leaves, and in_stall_o is high while busy.
// Reset: asynchronous, active low; returns to idle with no result pending.
module fp64_truncated_remainder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fp64_rem_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fp64_rem_pkg::out_t  out_data_o
);

  fp64_rem_pkg::state_e state_q, state_d;
  logic [52:0] r_q, r_d;       // partial remainder, below mb during reduction
  logic [52:0] mb_q, mb_d;
  logic [52:0] ma_q, ma_d;     // dividend bits still to shift in
  logic [11:0] cnt_q, cnt_d;   // remaining reduction steps
  logic [10:0] e_q, e_d;
  logic        sign_q, sign_d;
  fp64_rem_pkg::out_t res_q, res_d;

  logic        acc;
  logic [10:0] ea, eb, eae, ebe;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_snan, b_snan;
  logic [53:0] sh, diff;

  assign acc = in_valid_i && !in_stall_o;
  assign ea  = in_data_i.a_bits[62:52];
  assign eb  = in_data_i.b_bits[62:52];
  assign fa  = in_data_i.a_bits[51:0];
  assign fb  = in_data_i.b_bits[51:0];
  assign eae = (ea == 11'd0) ? 11'd1 : ea;
  assign ebe = (eb == 11'd0) ? 11'd1 : eb;
  assign a_nan  = (ea == fp64_rem_pkg::ExpAllOnes) && (fa != 52'd0);
  assign b_nan  = (eb == fp64_rem_pkg::ExpAllOnes) && (fb != 52'd0);
  assign a_snan = a_nan && !fa[51];
  assign b_snan = b_nan && !fb[51];

  // Shift-subtract unit, used by every reduction step.
  assign sh   = {r_q, ma_q[52]};
  assign diff = sh - {1'b0, mb_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fp64_rem_pkg::ST_IDLE: begin
        if (acc) begin
          if (a_nan || b_nan || ea == fp64_rem_pkg::ExpAllOnes ||
              eb == fp64_rem_pkg::ExpAllOnes || (eb == 11'd0 && fb == 52'd0) ||
              (ea == 11'd0 && fa == 52'd0) || eae < ebe) begin
            state_d = fp64_rem_pkg::ST_DONE;
          end else begin
            state_d = fp64_rem_pkg::ST_REDUCE;
          end
        end
      end
      fp64_rem_pkg::ST_REDUCE: if (cnt_q == 12'd1) state_d = fp64_rem_pkg::ST_NORM;
      fp64_rem_pkg::ST_NORM: begin
        if (r_q == 53'd0 || r_q[52] || e_q == 11'd1) state_d = fp64_rem_pkg::ST_DONE;
      end
      fp64_rem_pkg::ST_DONE: if (!out_stall_i) state_d = fp64_rem_pkg::ST_IDLE;
      default: state_d = fp64_rem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    r_d = r_q; mb_d = mb_q; ma_d = ma_q; cnt_d = cnt_q;
    e_d = e_q; sign_d = sign_q; res_d = res_q;
    unique case (state_q)
      fp64_rem_pkg::ST_IDLE: begin
        sign_d = in_data_i.a_bits[63];
        e_d    = ebe;
        r_d    = 53'd0;
        ma_d   = {ea != 11'd0, fa};
        mb_d   = {eb != 11'd0, fb};
        cnt_d  = {1'b0, eae - ebe} + 12'd53;
        res_d.invalid_flag = 1'b0;
        res_d.result_bits  = in_data_i.a_bits;
        if (a_nan || b_nan) begin
          res_d.result_bits  = fp64_rem_pkg::CanonNan;
          res_d.invalid_flag = a_snan || b_snan;
        end else if (ea == fp64_rem_pkg::ExpAllOnes) begin
          res_d.result_bits  = fp64_rem_pkg::CanonNan;
          res_d.invalid_flag = 1'b1;
        end else if (eb == fp64_rem_pkg::ExpAllOnes) begin
          res_d.result_bits  = in_data_i.a_bits;
        end else if (eb == 11'd0 && fb == 52'd0) begin
          res_d.result_bits  = fp64_rem_pkg::CanonNan;
          res_d.invalid_flag = 1'b1;
        end
      end
      fp64_rem_pkg::ST_REDUCE: begin
        r_d   = diff[53] ? sh[52:0] : diff[52:0];
        ma_d  = {ma_q[51:0], 1'b0};
        cnt_d = cnt_q - 12'd1;
      end
      fp64_rem_pkg::ST_NORM: begin
        if (r_q == 53'd0) begin
          res_d.result_bits = {sign_q, 63'd0};
        end else if (r_q[52]) begin
          res_d.result_bits = {sign_q, e_q, r_q[51:0]};
        end else if (e_q == 11'd1) begin
          res_d.result_bits = {sign_q, 11'd0, r_q[51:0]};
        end else begin
          r_d = {r_q[51:0], 1'b0};
          e_d = e_q - 11'd1;
        end
      end
      fp64_rem_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fp64_rem_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; mb_q <= mb_d; ma_q <= ma_d; cnt_q <= cnt_d;
    e_q <= e_d; sign_q <= sign_d; res_q <= res_d;
  end

  assign in_stall_o  = (state_q != fp64_rem_pkg::ST_IDLE);
  assign out_valid_o = (state_q == fp64_rem_pkg::ST_DONE);
  assign out_data_o  = res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fp64_rem_pkg::ST_REDUCE) |=> (r_q < mb_q))
    else $error("partial remainder not reduced");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule
